@@ hw/rtl/aat_pkg.sv @@
// Package for the AABB affine transform core: widths, types and register reset values.
package aat_pkg;

   localparam int COORD_W   = 16;
   localparam int FRAC_W    = 12;
   localparam int ENTRY_W   = 16;
   localparam int TRANS_W   = 16;
   localparam int OUT_W     = 21;
   localparam int AXES      = 3;
   localparam int REG_W     = 48;
   localparam int CSR_IDX_W = 2;

   localparam int PROD_W = COORD_W + ENTRY_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int SH_W   = SUM_W + 1 - FRAC_W;
   localparam int MAX_A  = (SH_W > TRANS_W) ? SH_W : TRANS_W;
   localparam int RES_W  = ((MAX_A > OUT_W) ? MAX_A : OUT_W) + 1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef logic signed [TRANS_W-1:0] trans_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [SUM_W:0]     sum_ext_type;
   typedef logic signed [SH_W-1:0]    shift_type;
   typedef logic signed [RES_W-1:0]   res_type;
   typedef logic signed [OUT_W-1:0]   out_type;
   typedef logic [REG_W-1:0]          reg_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_X       = 2'd0,
      CSR_ROW_Y       = 2'd1,
      CSR_ROW_Z       = 2'd2,
      CSR_TRANSLATION = 2'd3
   } csr_idx_type;

   localparam reg_type ROW_X_RST = reg_type'(64'd1 << FRAC_W);
   localparam reg_type ROW_Y_RST = reg_type'(64'd1 << (ENTRY_W + FRAC_W));
   localparam reg_type ROW_Z_RST = reg_type'(64'd1 << (2 * ENTRY_W + FRAC_W));
   localparam reg_type TRANS_RST = '0;

   localparam sum_ext_type CEIL_ADD = sum_ext_type'((64'd1 << FRAC_W) - 64'd1);
   localparam res_type     SAT_HI   = res_type'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
   localparam res_type     SAT_LO   = res_type'(-(64'sd1 <<< (OUT_W - 1)));

endpackage

@@ hw/rtl/aat_if.sv @@
// Channel interfaces for the AABB affine transform core: box input, box result, register writes.
interface aat_req_if;
   logic                  valid;
   logic                  ready;
   aat_pkg::coord_type    in_min_x;
   aat_pkg::coord_type    in_min_y;
   aat_pkg::coord_type    in_min_z;
   aat_pkg::coord_type    in_max_x;
   aat_pkg::coord_type    in_max_y;
   aat_pkg::coord_type    in_max_z;

   modport source (output valid, in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
                   input ready);
   modport sink   (input valid, in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
                   output ready);
endinterface

interface aat_rsp_if;
   logic                  valid;
   logic                  ready;
   aat_pkg::out_type      out_min_x;
   aat_pkg::out_type      out_min_y;
   aat_pkg::out_type      out_min_z;
   aat_pkg::out_type      out_max_x;
   aat_pkg::out_type      out_max_y;
   aat_pkg::out_type      out_max_z;

   modport source (output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y,
                   out_max_z, input ready);
   modport sink   (input valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y,
                   out_max_z, output ready);
endinterface

interface aat_csr_if;
   logic                  valid;
   logic                  ready;
   aat_pkg::csr_idx_type  index;
   aat_pkg::reg_type      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/aabb_affine_transform_core.sv @@
// Top level of the AABB affine transform core: config registers and four-stage box pipeline.
// Takes one box per cycle while the pipeline advances and returns the enclosing box of its image
// under the programmed Q4.12 matrix plus translation. Its stages are the input register, 18 parallel
// 16x16 multipliers, min/max ordering and column sums, and floor/ceil, translation and saturation
// into the result register. The whole pipeline advances together whenever the result register
// is empty or being taken, so throughput is one transaction per cycle when the sink keeps ready
// high. Register writes are always taken, as ready is tied high, and must only happen
// while no box is in flight.
module aabb_affine_transform_core (
   input  logic      clock,
   input  logic      reset,
   aat_req_if.sink   req_bus,
   aat_rsp_if.source rsp_bus,
   aat_csr_if.sink   csr_bus
);
   import aat_pkg::*;

   reg_type   row_ff [AXES];
   reg_type   trans_ff;

   logic      adv;
   logic      v0_ff, v1_ff, v2_ff, rsp_valid_ff;

   coord_type lo0_ff [AXES];
   coord_type hi0_ff [AXES];
   coord_type lo_in  [AXES];
   coord_type hi_in  [AXES];

   prod_type  plo_in [AXES][AXES];
   prod_type  phi_in [AXES][AXES];
   prod_type  plo1_ff [AXES][AXES];
   prod_type  phi1_ff [AXES][AXES];

   sum_type   smin_in [AXES];
   sum_type   smax_in [AXES];
   sum_type   smin2_ff [AXES];
   sum_type   smax2_ff [AXES];

   out_type   omin_in [AXES];
   out_type   omax_in [AXES];
   out_type   omin_ff [AXES];
   out_type   omax_ff [AXES];

   // configuration registers
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= ROW_X_RST;
         row_ff[1] <= ROW_Y_RST;
         row_ff[2] <= ROW_Z_RST;
         trans_ff  <= TRANS_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_ROW_X:       row_ff[0] <= csr_bus.data;
            CSR_ROW_Y:       row_ff[1] <= csr_bus.data;
            CSR_ROW_Z:       row_ff[2] <= csr_bus.data;
            CSR_TRANSLATION: trans_ff  <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // pipeline control
   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v0_ff        <= req_bus.valid;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   // stage 0: input register
   assign lo_in[0] = req_bus.in_min_x;
   assign lo_in[1] = req_bus.in_min_y;
   assign lo_in[2] = req_bus.in_min_z;
   assign hi_in[0] = req_bus.in_max_x;
   assign hi_in[1] = req_bus.in_max_y;
   assign hi_in[2] = req_bus.in_max_z;

   always_ff @(posedge clock) begin
      if (adv && req_bus.valid) begin
         lo0_ff <= lo_in;
         hi0_ff <= hi_in;
      end
   end

   // stage 1: products
   always_comb begin
      entry_type m;
      m = '0;
      for (int i = 0; i < AXES; i++) begin
         for (int j = 0; j < AXES; j++) begin
            m = entry_type'(row_ff[i][ENTRY_W*j +: ENTRY_W]);
            plo_in[i][j] = prod_type'(m) * prod_type'(lo0_ff[j]);
            phi_in[i][j] = prod_type'(m) * prod_type'(hi0_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         plo1_ff <= plo_in;
         phi1_ff <= phi_in;
      end
   end

   // stage 2: order each product pair, sum columns
   always_comb begin
      sum_type acc_lo;
      sum_type acc_hi;
      acc_lo = '0;
      acc_hi = '0;
      for (int i = 0; i < AXES; i++) begin
         acc_lo = '0;
         acc_hi = '0;
         for (int j = 0; j < AXES; j++) begin
            if (plo1_ff[i][j] < phi1_ff[i][j]) begin
               acc_lo = acc_lo + sum_type'(plo1_ff[i][j]);
               acc_hi = acc_hi + sum_type'(phi1_ff[i][j]);
            end else begin
               acc_lo = acc_lo + sum_type'(phi1_ff[i][j]);
               acc_hi = acc_hi + sum_type'(plo1_ff[i][j]);
            end
         end
         smin_in[i] = acc_lo;
         smax_in[i] = acc_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         smin2_ff <= smin_in;
         smax2_ff <= smax_in;
      end
   end

   // stage 3: floor/ceil, translate, saturate
   always_comb begin
      sum_ext_type lo_ext;
      sum_ext_type hi_ext;
      shift_type   lo_sh;
      shift_type   hi_sh;
      res_type     t_r;
      res_type     lo_r;
      res_type     hi_r;
      lo_ext = '0;
      hi_ext = '0;
      lo_sh  = '0;
      hi_sh  = '0;
      t_r    = '0;
      lo_r   = '0;
      hi_r   = '0;
      for (int i = 0; i < AXES; i++) begin
         lo_ext = sum_ext_type'(smin2_ff[i]);
         hi_ext = sum_ext_type'(smax2_ff[i]) + CEIL_ADD;
         lo_sh  = shift_type'(lo_ext >>> FRAC_W);
         hi_sh  = shift_type'(hi_ext >>> FRAC_W);
         t_r    = res_type'(trans_type'(trans_ff[TRANS_W*i +: TRANS_W]));
         lo_r   = res_type'(lo_sh) + t_r;
         hi_r   = res_type'(hi_sh) + t_r;
         if (lo_r > SAT_HI) begin
            lo_r = SAT_HI;
         end else if (lo_r < SAT_LO) begin
            lo_r = SAT_LO;
         end
         if (hi_r > SAT_HI) begin
            hi_r = SAT_HI;
         end else if (hi_r < SAT_LO) begin
            hi_r = SAT_LO;
         end
         omin_in[i] = out_type'(lo_r);
         omax_in[i] = out_type'(hi_r);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         omin_ff <= omin_in;
         omax_ff <= omax_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_min_x = omin_ff[0];
   assign rsp_bus.out_min_y = omin_ff[1];
   assign rsp_bus.out_min_z = omin_ff[2];
   assign rsp_bus.out_max_x = omax_ff[0];
   assign rsp_bus.out_max_y = omax_ff[1];
   assign rsp_bus.out_max_z = omax_ff[2];

`ifndef SYNTHESIS
   // ordered products keep every min sum at or below its max sum
   a_sum_order: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (smin2_ff[0] <= smax2_ff[0]) && (smin2_ff[1] <= smax2_ff[1]) &&
                (smin2_ff[2] <= smax2_ff[2]))
      else $error("column sums out of order");

   // floor/ceil and clamping are monotone, so the result box is never inverted
   a_out_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (omin_ff[0] <= omax_ff[0]) && (omin_ff[1] <= omax_ff[1]) &&
                       (omin_ff[2] <= omax_ff[2]))
      else $error("result box inverted");

   // a stalled result must not be replaced or dropped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |=> rsp_valid_ff && $stable(omin_ff[0]) &&
                                          $stable(omax_ff[2]))
      else $error("stalled result changed");
`endif

endmodule

@@ bench/testbench.sv @@
// Testbench for the AABB affine transform core: directed table, random boxes, predictor check.
`timescale 1ns / 1ps

module testbench;
   import aat_pkg::*;

   typedef struct {
      coord_type lo [3];
      coord_type hi [3];
   } box_in_type;

   typedef struct {
      out_type lo [3];
      out_type hi [3];
   } box_out_type;

   typedef enum {STEP_WRITE, STEP_BOX} step_kind_type;

   typedef struct {
      step_kind_type kind;
      csr_idx_type   index;
      reg_type       data;
      box_in_type    box;
      bit            known;
      box_out_type   want;
   } plan_step_type;

   localparam longint OUT_HI = (longint'(1) <<< (OUT_W - 1)) - 1;
   localparam longint OUT_LO = -OUT_HI - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aat_req_if req_bus ();
   aat_rsp_if rsp_bus ();
   aat_csr_if csr_bus ();

   aabb_affine_transform_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   reg_type       matrix_rows [3] = '{ROW_X_RST, ROW_Y_RST, ROW_Z_RST};
   reg_type       offsets         = TRANS_RST;
   box_out_type   expected_boxes [$];
   plan_step_type plan [$];
   string         axis_name [3]   = '{"x", "y", "z"};
   int            mismatches      = 0;
   int            burst_left      = 0;
   bit            req_up          = 1'b0;
   bit            csr_up          = 1'b0;
   bit            hold_wanted     = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   task automatic report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   function automatic out_type clamp_out(longint v);
      if (v > OUT_HI) return out_type'(OUT_HI);
      if (v < OUT_LO) return out_type'(OUT_LO);
      return out_type'(v);
   endfunction

   // Enclosing box: ordered products per column, floor the min sum, ceil the max sum.
   function automatic box_out_type enclose_box(box_in_type b);
      box_out_type r;
      longint      m, p, q, lo_sum, hi_sum, t;
      for (int i = 0; i < AXES; i++) begin
         lo_sum = 0;
         hi_sum = 0;
         for (int j = 0; j < AXES; j++) begin
            m = longint'(entry_type'(matrix_rows[i][ENTRY_W*j +: ENTRY_W]));
            p = m * longint'(b.lo[j]);
            q = m * longint'(b.hi[j]);
            if (p < q) begin
               lo_sum += p;
               hi_sum += q;
            end else begin
               lo_sum += q;
               hi_sum += p;
            end
         end
         t = longint'(trans_type'(offsets[TRANS_W*i +: TRANS_W]));
         r.lo[i] = clamp_out((lo_sum >>> FRAC_W) + t);
         r.hi[i] = clamp_out(-((-hi_sum) >>> FRAC_W) + t);
      end
      return r;
   endfunction

   function automatic coord_type random_coord();
      case ($urandom_range(0, 7))
         0: return coord_type'(16'h8000);
         1: return coord_type'(16'h7FFF);
         2: return coord_type'(int'($urandom_range(0, 64)) - 32);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic box_in_type random_box();
      box_in_type b;
      coord_type  a, c;
      bit         ordered;
      ordered = $urandom_range(0, 4) != 0;
      for (int j = 0; j < AXES; j++) begin
         a = random_coord();
         c = random_coord();
         if (ordered && a > c) begin
            b.lo[j] = c;
            b.hi[j] = a;
         end else begin
            b.lo[j] = a;
            b.hi[j] = c;
         end
      end
      return b;
   endfunction

   function automatic entry_type random_entry();
      case ($urandom_range(0, 6))
         0: return entry_type'(16'h8000);
         1: return entry_type'(16'h7FFF);
         2: return '0;
         3: return entry_type'(int'($urandom_range(0, 16)) - 8);
         4: return entry_type'((int'($urandom_range(0, 16)) - 8) * (1 << FRAC_W));
         default: return entry_type'($urandom);
      endcase
   endfunction

   function automatic reg_type random_triple();
      reg_type r;
      for (int j = 0; j < AXES; j++) r[ENTRY_W*j +: ENTRY_W] = random_entry();
      return r;
   endfunction

   function automatic void add_write(csr_idx_type idx, reg_type val);
      plan_step_type s;
      s.kind  = STEP_WRITE;
      s.index = idx;
      s.data  = val;
      s.known = 1'b0;
      plan.push_back(s);
   endfunction

   function automatic void add_box(box_in_type b);
      plan_step_type s;
      s.kind  = STEP_BOX;
      s.box   = b;
      s.known = 1'b0;
      plan.push_back(s);
   endfunction

   function automatic void add_known(box_in_type b, box_out_type want);
      plan_step_type s;
      s.kind  = STEP_BOX;
      s.box   = b;
      s.known = 1'b1;
      s.want  = want;
      plan.push_back(s);
   endfunction

   task automatic program_reg(csr_idx_type idx, reg_type val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      csr_up = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_ROW_X:       matrix_rows[0] = val;
         CSR_ROW_Y:       matrix_rows[1] = val;
         CSR_ROW_Z:       matrix_rows[2] = val;
         CSR_TRANSLATION: offsets        = val;
         default:         ;
      endcase
   endtask

   task automatic send_box(box_in_type b, bit known, box_out_type want);
      if (csr_up) begin
         csr_bus.valid <= 1'b0;
         csr_up = 1'b0;
      end
      req_bus.valid    <= 1'b1;
      req_bus.in_min_x <= b.lo[0];
      req_bus.in_min_y <= b.lo[1];
      req_bus.in_min_z <= b.lo[2];
      req_bus.in_max_x <= b.hi[0];
      req_bus.in_max_y <= b.hi[1];
      req_bus.in_max_z <= b.hi[2];
      req_up = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      if (known) expected_boxes.push_back(want);
      else expected_boxes.push_back(enclose_box(b));
   endtask

   // Sender bursts: after each transaction either continue or drop valid for a gap.
   task automatic pace();
      int gap;
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            req_up = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      if (req_up) begin
         req_bus.valid <= 1'b0;
         req_up = 1'b0;
      end
      if (csr_up) begin
         csr_bus.valid <= 1'b0;
         csr_up = 1'b0;
      end
      while (expected_boxes.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   initial begin : stimulus
      box_out_type none;
      req_bus.valid    <= 1'b0;
      req_bus.in_min_x <= '0;
      req_bus.in_min_y <= '0;
      req_bus.in_min_z <= '0;
      req_bus.in_max_x <= '0;
      req_bus.in_max_y <= '0;
      req_bus.in_max_z <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= CSR_ROW_X;
      csr_bus.data     <= '0;

      // identity at reset: result equals input, inverted axes come back swapped
      add_known('{'{0, 0, 0}, '{0, 0, 0}}, '{'{0, 0, 0}, '{0, 0, 0}});
      add_known('{'{-32768, -32768, -32768}, '{32767, 32767, 32767}},
                '{'{-32768, -32768, -32768}, '{32767, 32767, 32767}});
      add_known('{'{32767, 32767, 32767}, '{32767, 32767, 32767}},
                '{'{32767, 32767, 32767}, '{32767, 32767, 32767}});
      add_known('{'{-32768, -32768, -32768}, '{-32768, -32768, -32768}},
                '{'{-32768, -32768, -32768}, '{-32768, -32768, -32768}});
      add_known('{'{100, -5, 32767}, '{-100, 5, -32768}},
                '{'{-100, -5, -32768}, '{100, 5, 32767}});
      add_known('{'{-1, 2, -3}, '{4, 5, 6}}, '{'{-1, 2, -3}, '{4, 5, 6}});

      // most negative entries, largest offset
      add_write(CSR_ROW_X, 48'h8000_8000_8000);
      add_write(CSR_ROW_Y, 48'h8000_8000_8000);
      add_write(CSR_ROW_Z, 48'h8000_8000_8000);
      add_write(CSR_TRANSLATION, 48'h7FFF_7FFF_7FFF);
      add_box('{'{-32768, -32768, -32768}, '{32767, 32767, 32767}});
      add_box('{'{-32768, -32768, -32768}, '{-32768, -32768, -32768}});
      add_box('{'{32767, 0, -32768}, '{-32768, 0, 32767}});
      add_box('{'{0, 0, 0}, '{0, 0, 0}});

      // most positive entries, most negative offset
      add_write(CSR_ROW_X, 48'h7FFF_7FFF_7FFF);
      add_write(CSR_ROW_Y, 48'h7FFF_7FFF_7FFF);
      add_write(CSR_ROW_Z, 48'h7FFF_7FFF_7FFF);
      add_write(CSR_TRANSLATION, 48'h8000_8000_8000);
      add_box('{'{-32768, -32768, -32768}, '{32767, 32767, 32767}});
      add_box('{'{32767, 32767, 32767}, '{32767, 32767, 32767}});
      add_box('{'{-32768, -32768, -32768}, '{-32768, -32768, -32768}});

      // fractional entries exercise floor and ceil
      add_write(CSR_ROW_X, 48'h0800_FFFF_0001);
      add_write(CSR_ROW_Y, 48'hF800_0001_FFFF);
      add_write(CSR_ROW_Z, 48'hE001_0000_1800);
      add_write(CSR_TRANSLATION, 48'h0001_FFFF_8000);
      add_box('{'{1, 1, 1}, '{3, 3, 3}});
      add_box('{'{-1, -1, -1}, '{1, 1, 1}});
      add_box('{'{-32768, -32768, -32768}, '{32767, 32767, 32767}});
      add_box('{'{5, -7, 9}, '{-5, 7, -9}});

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[k]) begin
         if (plan[k].kind == STEP_WRITE) begin
            if (k == 0 || plan[k-1].kind != STEP_WRITE) wait_idle();
            program_reg(plan[k].index, plan[k].data);
         end else begin
            send_box(plan[k].box, plan[k].known, plan[k].want);
            pace();
         end
      end

      for (int phase = 0; phase < 7; phase++) begin
         wait_idle();
         program_reg(CSR_ROW_X, random_triple());
         program_reg(CSR_ROW_Y, random_triple());
         program_reg(CSR_ROW_Z, random_triple());
         program_reg(CSR_TRANSLATION, random_triple());
         if (phase == 0) hold_wanted = 1'b1;
         repeat (100) begin
            send_box(random_box(), 1'b0, none);
            pace();
         end
      end

      wait_idle();
      if (mismatches == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end

   // Result side: stretches of full, mostly-high and random ready, plus long hold-offs.
   initial begin : sink_pacing
      int seg, len, mode;
      rsp_bus.ready <= 1'b0;
      seg = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         seg++;
         if (hold_wanted || seg % 16 == 0) begin
            hold_wanted = 1'b0;
            repeat (48) begin
               @(posedge clock);
               rsp_bus.ready <= 1'b0;
            end
         end else begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(4, 40);
            repeat (len) begin
               @(posedge clock);
               case (mode)
                  0:       rsp_bus.ready <= 1'b1;
                  1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                  default: rsp_bus.ready <= $urandom_range(0, 1);
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin : result_check
      box_out_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.lo = '{rsp_bus.out_min_x, rsp_bus.out_min_y, rsp_bus.out_min_z};
         got.hi = '{rsp_bus.out_max_x, rsp_bus.out_max_y, rsp_bus.out_max_z};
         if (expected_boxes.size() == 0) report_mismatch("result transaction with none expected");
         else begin
            want = expected_boxes.pop_front();
            for (int i = 0; i < AXES; i++) begin
               if (got.lo[i] !== want.lo[i])
                  report_mismatch($sformatf("out_min_%s got %0d want %0d",
                                            axis_name[i], got.lo[i], want.lo[i]));
               if (got.hi[i] !== want.hi[i])
                  report_mismatch($sformatf("out_max_%s got %0d want %0d",
                                            axis_name[i], got.hi[i], want.hi[i]));
            end
         end
      end
   end

endmodule
